// ===== rtl/dacc_pkg.sv =====
package dacc_pkg;

    localparam int MEM_WORDS_DEF = 1000;
    localparam int WORD_W        = 18;
    localparam int MAG_W         = 17;
    localparam int DIV_BITS      = MAG_W;
    localparam int DIV_CNT_W     = $clog2(DIV_BITS);
    localparam int RECIP_SHIFT   = 27;
    // ceil(2^27 / 1000): exact quotient for any 17-bit magnitude
    localparam logic [17:0] RECIP_1000 = 18'(((1 << RECIP_SHIFT) + 999) / 1000);

    localparam logic signed [WORD_W-1:0] WORD_MAX = 18'sd99999;
    localparam logic signed [WORD_W-1:0] WORD_MIN = -18'sd99999;

    localparam logic [7:0] OP_READ    = 8'd10;
    localparam logic [7:0] OP_WRITE   = 8'd11;
    localparam logic [7:0] OP_NEWLINE = 8'd12;
    localparam logic [7:0] OP_LOAD    = 8'd20;
    localparam logic [7:0] OP_STORE   = 8'd21;
    localparam logic [7:0] OP_ADD     = 8'd30;
    localparam logic [7:0] OP_SUB     = 8'd31;
    localparam logic [7:0] OP_DIV     = 8'd32;
    localparam logic [7:0] OP_MUL     = 8'd33;
    localparam logic [7:0] OP_MOD     = 8'd34;
    localparam logic [7:0] OP_POW     = 8'd35;
    localparam logic [7:0] OP_BR      = 8'd40;
    localparam logic [7:0] OP_BRNEG   = 8'd41;
    localparam logic [7:0] OP_BRZERO  = 8'd42;
    localparam logic [7:0] OP_HALT    = 8'd43;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_WRITE    = 4'd1,
        ST_NEWLINE  = 4'd2,
        ST_HALTED   = 4'd3,
        ST_LOADDONE = 4'd4,
        ST_MEMFULL  = 4'd5,
        ST_OVERFLOW = 4'd6,
        ST_DIVZERO  = 4'd7,
        ST_MODZERO  = 4'd8,
        ST_NEGEXP   = 4'd9,
        ST_BADOP    = 4'd10,
        ST_PCOUT    = 4'd11,
        ST_STOPPED  = 4'd12
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC1,
        S_DEC2,
        S_OPRD,
        S_EXEC,
        S_DIV,
        S_MUL,
        S_MCHK,
        S_DONE
    } state_t;

    function automatic logic word_ok(input logic signed [35:0] v);
        return (v >= 36'(WORD_MIN)) && (v <= 36'(WORD_MAX));
    endfunction

endpackage

// ===== rtl/decimal_accumulator_cpu.sv =====
// Load beat: accepted in S_IDLE, result issued from S_DONE. Step beat: S_DEC1, S_DEC2,
// S_OPRD, S_EXEC and S_DONE for simple ops; multiply adds S_MUL and S_MCHK; divide and
// remainder add S_DIV (17-step restoring divider); power loops S_MUL/S_MCHK, at most 17
// multiplies before overflow. One item at a time; the next beat is taken the cycle
// after the result register loads. Reset is asynchronous; afterwards a clearing pass
// zeroes the word memory, during which in_stall stays high.
module decimal_accumulator_cpu #(
    parameter int MEM_WORDS = dacc_pkg::MEM_WORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [17:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         status,
    output logic signed [17:0] output_value,
    output logic signed [17:0] accumulator_value,
    output logic [9:0]         program_counter,
    output logic signed [17:0] instruction_word,
    output logic [6:0]         opcode,
    output logic [9:0]         operand_address
);

    import dacc_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [9:0]    MEM_LIMIT = 10'(MEM_WORDS);
    localparam logic [AW-1:0] CLR_LAST  = AW'(MEM_WORDS - 1);

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic signed [17:0]      acc_reg, acc_next;
    logic [9:0]              pc_reg, pc_next;
    logic [9:0]              lp_reg, lp_next;
    logic                    stopped_reg, stopped_next;
    logic signed [17:0]      val_reg, val_next;
    logic signed [17:0]      ir_reg, ir_next;
    logic [16:0]             mag_reg, mag_next;
    logic [7:0]              op_reg, op_next;
    logic [9:0]              addr_reg, addr_next;
    logic signed [17:0]      m_reg, m_next;
    status_t                 st_reg, st_next;
    logic signed [17:0]      outv_reg, outv_next;
    logic signed [17:0]      pow_reg, pow_next;
    logic [16:0]             exp_reg, exp_next;
    logic signed [35:0]      prod_reg, prod_next;
    logic [16:0]             d_reg, d_next;
    logic [16:0]             dq_reg, dq_next;
    logic [16:0]             rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;

    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_next;
    logic signed [17:0]      output_value_reg, output_value_next;
    logic signed [17:0]      accumulator_value_reg, accumulator_value_next;
    logic [9:0]              program_counter_reg, program_counter_next;
    logic signed [17:0]      instruction_word_reg, instruction_word_next;
    logic [6:0]              opcode_reg, opcode_next;
    logic [9:0]              operand_address_reg, operand_address_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [17:0]             ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [17:0]             ram_rdata;
    logic signed [17:0]      q;

    logic                    accept;
    logic [34:0]             recip_p;
    logic [7:0]              op_est;
    logic [16:0]             op_x1000;
    logic signed [17:0]      mul_a, mul_b;
    logic signed [35:0]      mul_p;
    logic signed [18:0]      sum_v;
    logic [17:0]             div_shift;
    logic                    div_ge;
    logic [16:0]             div_rem, div_quo;
    logic [16:0]             acc_mag, q_mag;
    logic                    needs_addr;

    dacc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q        = $signed(ram_rdata);
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // decode: op = mag / 1000 by reciprocal, addr = mag - op * 1000
    assign recip_p  = 35'(mag_reg) * 35'(RECIP_1000);
    assign op_est   = recip_p[34:27];
    assign op_x1000 = (17'(op_est) << 10) - (17'(op_est) << 4) - (17'(op_est) << 3);

    assign mul_a = (op_reg == OP_POW) ? pow_reg : acc_reg;
    assign mul_b = (op_reg == OP_POW) ? acc_reg : m_reg;
    assign mul_p = mul_a * mul_b;

    assign sum_v = (op_reg == OP_ADD) ? (19'(acc_reg) + 19'(q)) : (19'(acc_reg) - 19'(q));

    assign acc_mag = acc_reg[17] ? 17'(-acc_reg) : acc_reg[16:0];
    assign q_mag   = q[17] ? 17'(-q) : q[16:0];

    // one restoring divide step
    assign div_shift = {rem_reg, dq_reg[16]};
    assign div_ge    = div_shift >= {1'b0, d_reg};
    assign div_rem   = div_ge ? 17'(div_shift - {1'b0, d_reg}) : div_shift[16:0];
    assign div_quo   = {dq_reg[15:0], div_ge};

    assign needs_addr = op_reg inside {OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
                                       OP_DIV, OP_MUL, OP_MOD, OP_POW, OP_BR, OP_BRNEG,
                                       OP_BRZERO};

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        acc_next     = acc_reg;
        pc_next      = pc_reg;
        lp_next      = lp_reg;
        stopped_next = stopped_reg;
        val_next     = val_reg;
        ir_next      = ir_reg;
        mag_next     = mag_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        m_next       = m_reg;
        st_next      = st_reg;
        outv_next    = outv_reg;
        pow_next     = pow_reg;
        exp_next     = exp_reg;
        prod_next    = prod_reg;
        d_next       = d_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;

        out_valid_next         = out_valid_reg && out_stall;
        status_next            = status_reg;
        output_value_next      = output_value_reg;
        accumulator_value_next = accumulator_value_reg;
        program_counter_next   = program_counter_reg;
        instruction_word_next  = instruction_word_reg;
        opcode_next            = opcode_reg;
        operand_address_next   = operand_address_reg;

        ram_we    = 1'b0;
        ram_waddr = lp_reg[AW-1:0];
        ram_wdata = value;
        ram_raddr = (state_reg == S_IDLE) ? pc_reg[AW-1:0] : addr_reg[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    val_next   = value;
                    ir_next    = '0;
                    op_next    = '0;
                    addr_next  = '0;
                    outv_next  = '0;
                    st_next    = ST_OK;
                    state_next = S_DONE;
                    if (!mode)
                    begin
                        if (lp_reg >= MEM_LIMIT)
                        begin
                            st_next = ST_MEMFULL;
                        end
                        else if (value == WORD_MAX || value == WORD_MIN)
                        begin
                            st_next = ST_LOADDONE;
                        end
                        else if (word_ok(36'(value)))
                        begin
                            ram_we  = 1'b1;
                            lp_next = lp_reg + 1'b1;
                        end
                    end
                    else if (stopped_reg)
                    begin
                        st_next = ST_STOPPED;
                    end
                    else if (pc_reg >= MEM_LIMIT)
                    begin
                        st_next = ST_PCOUT;
                    end
                    else
                    begin
                        state_next = S_DEC1;
                    end
                end
            end

            S_DEC1:
            begin
                ir_next    = q;
                mag_next   = q_mag;
                pc_next    = pc_reg + 1'b1;
                state_next = S_DEC2;
            end

            S_DEC2:
            begin
                op_next    = op_est;
                addr_next  = 10'(mag_reg - op_x1000);
                state_next = S_OPRD;
            end

            S_OPRD:
            begin
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                m_next     = q;
                if (needs_addr && addr_reg >= MEM_LIMIT)
                begin
                    st_next = ST_PCOUT;
                end
                else
                begin
                    case (op_reg)
                        OP_READ:
                        begin
                            if (word_ok(36'(val_reg)))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = addr_reg[AW-1:0];
                                ram_wdata = val_reg;
                            end
                            else
                            begin
                                st_next = ST_OVERFLOW;
                            end
                        end
                        OP_WRITE:
                        begin
                            st_next   = ST_WRITE;
                            outv_next = q;
                        end
                        OP_NEWLINE: st_next = ST_NEWLINE;
                        OP_LOAD:    acc_next = q;
                        OP_STORE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = addr_reg[AW-1:0];
                            ram_wdata = acc_reg;
                        end
                        OP_ADD, OP_SUB:
                        begin
                            if (word_ok(36'(sum_v)))
                            begin
                                acc_next = sum_v[17:0];
                            end
                            else
                            begin
                                st_next = ST_OVERFLOW;
                            end
                        end
                        OP_DIV, OP_MOD:
                        begin
                            if (q == '0)
                            begin
                                st_next = (op_reg == OP_DIV) ? ST_DIVZERO : ST_MODZERO;
                            end
                            else
                            begin
                                d_next     = q_mag;
                                dq_next    = acc_mag;
                                rem_next   = '0;
                                cnt_next   = '0;
                                state_next = S_DIV;
                            end
                        end
                        OP_MUL: state_next = S_MUL;
                        OP_POW:
                        begin
                            if (q[17])
                            begin
                                st_next = ST_NEGEXP;
                            end
                            else if (q == '0)
                            begin
                                acc_next = 18'sd1;
                            end
                            else if (acc_reg == 18'sd0 || acc_reg == 18'sd1)
                            begin
                                acc_next = acc_reg;
                            end
                            else if (acc_reg == -18'sd1)
                            begin
                                acc_next = q[0] ? -18'sd1 : 18'sd1;
                            end
                            else
                            begin
                                pow_next   = 18'sd1;
                                exp_next   = q[16:0];
                                state_next = S_MUL;
                            end
                        end
                        OP_BR:     pc_next = addr_reg;
                        OP_BRNEG:
                        begin
                            if (acc_reg[17])
                            begin
                                pc_next = addr_reg;
                            end
                        end
                        OP_BRZERO:
                        begin
                            if (acc_reg == '0)
                            begin
                                pc_next = addr_reg;
                            end
                        end
                        OP_HALT: st_next = ST_HALTED;
                        default: st_next = ST_BADOP;
                    endcase
                end
            end

            S_DIV:
            begin
                rem_next = div_rem;
                dq_next  = div_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_BITS - 1))
                begin
                    state_next = S_DONE;
                    if (op_reg == OP_DIV)
                    begin
                        acc_next = (acc_reg[17] ^ m_reg[17]) ? -$signed({1'b0, div_quo})
                                                             : $signed({1'b0, div_quo});
                    end
                    else
                    begin
                        acc_next = acc_reg[17] ? -$signed({1'b0, div_rem})
                                               : $signed({1'b0, div_rem});
                    end
                end
            end

            S_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_MCHK;
            end

            S_MCHK:
            begin
                if (!word_ok(prod_reg))
                begin
                    st_next    = ST_OVERFLOW;
                    state_next = S_DONE;
                end
                else if (op_reg == OP_MUL)
                begin
                    acc_next   = prod_reg[17:0];
                    state_next = S_DONE;
                end
                else
                begin
                    pow_next = prod_reg[17:0];
                    exp_next = exp_reg - 1'b1;
                    if (exp_reg == 17'd1)
                    begin
                        acc_next   = prod_reg[17:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    status_next            = st_reg;
                    output_value_next      = outv_reg;
                    accumulator_value_next = acc_reg;
                    program_counter_next   = pc_reg;
                    instruction_word_next  = ir_reg;
                    opcode_next            = op_reg[6:0];
                    operand_address_next   = addr_reg;
                    if (st_reg >= ST_OVERFLOW || st_reg == ST_HALTED)
                    begin
                        stopped_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            acc_reg       <= '0;
            pc_reg        <= '0;
            lp_reg        <= '0;
            stopped_reg   <= 1'b0;
            cnt_reg       <= '0;
            exp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            acc_reg       <= acc_next;
            pc_reg        <= pc_next;
            lp_reg        <= lp_next;
            stopped_reg   <= stopped_next;
            cnt_reg       <= cnt_next;
            exp_reg       <= exp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        ir_reg   <= ir_next;
        mag_reg  <= mag_next;
        op_reg   <= op_next;
        addr_reg <= addr_next;
        m_reg    <= m_next;
        st_reg   <= st_next;
        outv_reg <= outv_next;
        pow_reg  <= pow_next;
        prod_reg <= prod_next;
        d_reg    <= d_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;

        status_reg            <= status_next;
        output_value_reg      <= output_value_next;
        accumulator_value_reg <= accumulator_value_next;
        program_counter_reg   <= program_counter_next;
        instruction_word_reg  <= instruction_word_next;
        opcode_reg            <= opcode_next;
        operand_address_reg   <= operand_address_next;
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign output_value      = output_value_reg;
    assign accumulator_value = accumulator_value_reg;
    assign program_counter   = program_counter_reg;
    assign instruction_word  = instruction_word_reg;
    assign opcode            = opcode_reg;
    assign operand_address   = operand_address_reg;

`ifndef NO_ASSERTIONS
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside result state");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(stopped_reg) |-> stopped_reg)
        else $error("stopped flag cleared without reset");

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= MEM_LIMIT)
        else $error("program counter beyond memory end");

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >= WORD_MIN) && (acc_reg <= WORD_MAX))
        else $error("accumulator outside five-digit range");
`endif

endmodule

// ===== rtl/dacc_ram.sv =====
module dacc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
